// ===== src/fpa_pkg.sv =====
// Shared types and constants for the flash page assembler.
// No dependencies; imported by fpa_ctrl, fpa_datapath and flash_page_assembler.
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int PAGE_BYTES_DEF = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'hFF;

  // Page zero patch positions
  localparam int W_VECTOR = 1;
  localparam int W_MOVED  = 6;
  localparam int W_CHECK  = 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_READ,
    S_SHOW
  } fpa_state_t;

  typedef struct packed {
    logic byte_wr;
    logic pad_wr;
    logic latch_page;
    logic clr_sum;
    logic rd_en;
    logic load_out;
    logic out_last;
  } fpa_cmd_t;

  typedef struct packed {
    logic out_free;
  } fpa_status_t;

endpackage

// ===== src/fpa_in_if.sv =====
// Input item channel of the flash page assembler.
// No dependencies.
`timescale 1ns / 1ps

interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  data_byte;
  logic [15:0] byte_address;
  logic        chunk_last;

  modport source(output valid, operation, data_byte, byte_address, chunk_last, input ready);
  modport sink(input valid, operation, data_byte, byte_address, chunk_last, output ready);
endinterface

// ===== src/fpa_out_if.sv =====
// Result item channel of the flash page assembler.
// No dependencies.
`timescale 1ns / 1ps

interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  page_number;
  logic [3:0]  word_index;
  logic [31:0] word_value;
  logic        last_word;

  modport source(output valid, page_number, word_index, word_value, last_word, input ready);
  modport sink(input valid, page_number, word_index, word_value, last_word, output ready);
endinterface

// ===== src/fpa_ctrl.sv =====
// Controller of the flash page assembler: fill counter, word counter, state machine.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_ctrl import fpa_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  localparam int WORDS = PAGE_BYTES / 4,
  localparam int WIDX  = $clog2(WORDS),
  localparam int FB    = $clog2(PAGE_BYTES)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_operation,
  output logic            in_ready,
  input  fpa_status_t     status,
  output fpa_cmd_t        cmd,
  output logic [WIDX-1:0] wr_addr,
  output logic [1:0]      wr_lane,
  output logic [WIDX-1:0] rd_addr,
  output logic [WIDX-1:0] out_idx
);

  fpa_state_t      state_r, state_nxt;
  logic [FB-1:0]   fill_r, fill_nxt;
  logic [WIDX-1:0] idx_r, idx_nxt;
  logic [WIDX-1:0] fill_word;
  logic            idx_last;

  assign fill_word = fill_r[FB-1:2];
  assign idx_last  = (idx_r == WIDX'(WORDS - 1));
  assign wr_addr   = fill_word;
  assign wr_lane   = fill_r[1:0];
  assign out_idx   = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    rd_addr   = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == OP_WRITE) begin
            cmd.byte_wr = 1'b1;
            if (fill_r == FB'(PAGE_BYTES - 1)) begin
              cmd.latch_page = 1'b1;
              fill_nxt       = '0;
              state_nxt      = S_READ;
            end else begin
              fill_nxt = fill_r + FB'(1);
            end
          end else if (fill_r != '0) begin
            cmd.latch_page = 1'b1;
            state_nxt      = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.pad_wr = 1'b1;
        if (fill_word == WIDX'(WORDS - 1)) begin
          fill_nxt  = '0;
          state_nxt = S_READ;
        end else begin
          fill_nxt = {WIDX'(fill_word + WIDX'(1)), 2'b00};
        end
      end
      S_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.clr_sum = 1'b1;
        idx_nxt     = '0;
        state_nxt   = S_SHOW;
      end
      S_SHOW: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = idx_last;
          if (idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
            rd_addr   = idx_r + WIDX'(1);
            idx_nxt   = idx_r + WIDX'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_operation == OP_FLUSH && fill_r == '0)
    |=> (state_r == S_IDLE && fill_r == '0))
    else $error("flush of empty page changed state");

  a_read_then_show: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_SHOW && idx_r == '0))
    else $error("emission did not start at word zero");

  a_last_word_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.out_last) |=> (state_r == S_IDLE && fill_r == '0))
    else $error("page not released after last word");

  a_pad_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAD && state_nxt == S_PAD) |=> (fill_r[1:0] == 2'b00))
    else $error("padding lost word alignment");

endmodule

// ===== src/fpa_datapath.sv =====
// Datapath of the flash page assembler: page memory, word assembly, page zero patch,
// output register. Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_datapath import fpa_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  localparam int WORDS = PAGE_BYTES / 4,
  localparam int WIDX  = $clog2(WORDS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_data_byte,
  input  logic [15:0]     in_byte_address,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  input  fpa_cmd_t        cmd,
  output fpa_status_t     status,
  input  logic [WIDX-1:0] wr_addr,
  input  logic [1:0]      wr_lane,
  input  logic [WIDX-1:0] rd_addr,
  input  logic [WIDX-1:0] out_idx,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [9:0]      out_page_number,
  output logic [3:0]      out_word_index,
  output logic [31:0]     out_word_value,
  output logic            out_last_word
);

  logic [31:0] mem [WORDS];

  logic [31:0]     acc_r;
  logic [31:0]     rdata_r;
  logic [31:0]     vector_r;
  logic [9:0]      page_r;
  logic            page0_r;
  logic [31:0]     sum_r;
  logic [31:0]     w1_r;
  logic            out_valid_r;
  logic [9:0]      out_page_r;
  logic [WIDX-1:0] out_idx_r;
  logic [31:0]     out_value_r;
  logic            out_last_r;

  logic [31:0]     pad_word;
  logic [31:0]     word_val;
  logic [15:0]     page_full;
  logic [WIDX+3:0] idx_ext;

  assign page_full       = 16'(in_byte_address / PAGE_BYTES);
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      pad_word[l*8 +: 8] = (2'(l) < wr_lane) ? acc_r[l*8 +: 8] : PAD_BYTE;
    end
  end

  always_comb begin
    word_val = rdata_r;
    if (page0_r) begin
      if (out_idx == WIDX'(W_VECTOR)) begin
        word_val = vector_r;
      end else if (out_idx == WIDX'(W_MOVED)) begin
        word_val = w1_r;
      end else if (out_idx == WIDX'(W_CHECK)) begin
        word_val = 32'd0 - sum_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      acc_r[wr_lane*8 +: 8] <= in_data_byte;
      if (wr_lane == 2'd3) begin
        mem[wr_addr] <= {in_data_byte, acc_r[23:0]};
      end
    end else if (cmd.pad_wr) begin
      mem[wr_addr] <= pad_word;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_page) begin
      page_r  <= page_full[9:0];
      page0_r <= (page_full == '0);
    end
    if (cmd.clr_sum) begin
      sum_r <= '0;
    end else if (cmd.load_out && out_idx < WIDX'(W_CHECK)) begin
      sum_r <= sum_r + word_val;
    end
    if (cmd.load_out && out_idx == WIDX'(W_VECTOR)) begin
      w1_r <= rdata_r;
    end
    if (cmd.load_out) begin
      out_page_r  <= page_r;
      out_idx_r   <= out_idx;
      out_value_r <= word_val;
      out_last_r  <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vector_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        vector_r <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign idx_ext         = {4'b0000, out_idx_r};
  assign out_valid       = out_valid_r;
  assign out_page_number = out_page_r;
  assign out_word_index  = idx_ext[3:0];
  assign out_word_value  = out_value_r;
  assign out_last_word   = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while held");

  a_no_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.byte_wr && cmd.pad_wr))
    else $error("data and pad write in one cycle");

  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_sum |=> (sum_r == '0))
    else $error("checksum not cleared at page start");

endmodule

// ===== src/flash_page_assembler.sv =====
// Flash page assembler top level: controller, datapath and channel wiring.
// Depends on fpa_pkg, fpa_in_if, fpa_out_if, fpa_ctrl, fpa_datapath.
// Order: a completing item (or a flush, after the pad words) leads to S_READ, which reads
//   word zero; S_SHOW then loads words one per cycle while the output is not stalled.
// Throughput: one byte item per cycle while a page fills; a completed page holds
//   off input through its pad words, the read and the emission of all its words.
// Reset: synchronous, clears fill count, state, output valid and the vector register.
`timescale 1ns / 1ps

module flash_page_assembler import fpa_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fpa_in_if.sink      in_ch,
  fpa_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int WORDS = PAGE_BYTES / 4;
  localparam int WIDX  = $clog2(WORDS);

  fpa_cmd_t        cmd;
  fpa_status_t     status;
  logic [WIDX-1:0] wr_addr;
  logic [1:0]      wr_lane;
  logic [WIDX-1:0] rd_addr;
  logic [WIDX-1:0] out_idx;
  logic            in_ready;

  assign in_ch.ready = in_ready;

  fpa_ctrl #(.PAGE_BYTES(PAGE_BYTES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .wr_lane      (wr_lane),
    .rd_addr      (rd_addr),
    .out_idx      (out_idx)
  );

  fpa_datapath #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_ch.data_byte),
    .in_byte_address (in_ch.byte_address),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .status          (status),
    .wr_addr         (wr_addr),
    .wr_lane         (wr_lane),
    .rd_addr         (rd_addr),
    .out_idx         (out_idx),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_page_number (out_ch.page_number),
    .out_word_index  (out_ch.word_index),
    .out_word_value  (out_ch.word_value),
    .out_last_word   (out_ch.last_word)
  );

endmodule
